@@ design/vpr_pkg.sv @@
// ----------------------------------------------------------------------------
// vpr_pkg
// Shared types, constants and helpers of the visibility pixel resolve unit.
// ----------------------------------------------------------------------------
package vpr_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int ACC_W      = 57;   // signed row sums
  localparam int DIV_STAGES = 31;   // one quotient bit per stage
  localparam int REM_W      = 88;   // partial remainder width

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0   = 3'd0,
    CFG_ROW1   = 3'd1,
    CFG_ROW2   = 3'd2,
    CFG_ROW3   = 3'd3,
    CFG_XSCALE = 3'd4,
    CFG_YSCALE = 3'd5
  } cfg_idx_e;

  localparam logic [63:0] ROW0_RST  = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ROW1_RST  = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROW2_RST  = 64'h0000_0100_0000_0000;
  localparam logic [63:0] ROW3_RST  = 64'h0100_0000_0000_0000;
  localparam logic [25:0] SCALE_RST = 26'd8192;

  localparam logic [31:0] EMPTY_PAYLOAD = 32'hFFFF_FFFF;
  localparam logic [31:0] Q16_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN       = 32'h8000_0000;

  typedef struct packed {
    logic        valid;
    logic [11:0] px;
    logic [11:0] py;
    logic [15:0] cid;
    logic [7:0]  tid;
    logic [7:0]  mid;
    logic [31:0] dbits;
  } pix_t;

  typedef struct packed {
    logic             wzero;
    logic [2:0]       neg;
    logic [2:0][31:0] undiv;
  } res_t;

  function automatic logic signed [15:0] coef(input logic [63:0] row, input logic [1:0] col);
    return signed'(row[16*col +: 16]);
  endfunction

  // signed row sum in Q.32 truncated toward zero to Q16.16, saturated
  function automatic logic [31:0] sat_undiv(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-17:0] m;
    logic [31:0] r;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    m   = mag[ACC_W-1:16];
    if (acc[ACC_W-1]) begin
      if (m >= (ACC_W-16)'(33'h0_8000_0000)) r = Q16_MIN;
      else r = 32'(-m);
    end else begin
      if (m > (ACC_W-16)'(33'h0_7FFF_FFFF)) r = Q16_MAX;
      else r = m[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/vpr_div.sv @@
// ----------------------------------------------------------------------------
// vpr_div
// Pipelined restoring divider: floor(num * 2^16 / den), one bit per stage.
// ----------------------------------------------------------------------------
module vpr_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [vpr_pkg::ACC_W-1:0]      num_i,
  input  logic [vpr_pkg::ACC_W-1:0]      den_i,
  output logic [vpr_pkg::DIV_STAGES-1:0] quo_o,
  output logic                           ovf_o
);

  localparam int NS = vpr_pkg::DIV_STAGES;
  localparam int RW = vpr_pkg::REM_W;
  localparam int AW = vpr_pkg::ACC_W;

  logic [RW-1:0] rem_q [NS];
  logic [AW-1:0] den_q [NS];
  logic [NS-1:0] quo_q [NS];
  logic          ovf_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = NS - 1 - s;
    logic [RW-1:0] rem_in, dsh;
    logic [AW-1:0] den_in;
    logic [NS-1:0] quo_in;
    logic          ovf_in, ge;

    if (s == 0) begin : g_first
      assign rem_in = RW'({num_i, 16'h0000});
      assign den_in = den_i;
      assign quo_in = '0;
      // quotient would reach 2^31: saturates downstream
      assign ovf_in = RW'(num_i) >= (RW'(den_i) << 15);
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    assign dsh = RW'(den_in) << K;
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_in - dsh : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= quo_in | (NS'(ge) << K);
        ovf_q[s] <= ovf_in;
      end
    end
  end

  assign quo_o = quo_q[NS-1];
  assign ovf_o = ovf_q[NS-1];

endmodule

@@ design/visibility_pixel_resolve_unit.sv @@
// Resolves one visibility-buffer pixel per clock, fully pipelined: a new word
// may enter every cycle while the output is not stalled. Each word passes four
// stages of decode, multiply, sum and magnitude, then the 31-stage divider
// (one bit per stage) that divides the world position by homogeneous w.
// Empty pixels and pixels outside the frame are dropped. The config port is
// always ready and must only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
// visibility_pixel_resolve_unit
// Pixel decode, inverse view-projection and Q16.16 world position.
// ----------------------------------------------------------------------------
module visibility_pixel_resolve_unit #(
  parameter int MAX_WIDTH  = vpr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vpr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel_x, pixel_y, depth_code, payload_word
  input  logic [87:0]                    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // out_x, out_y, cluster, triangle, material, depth_float_bits,
  // world_x, world_y, world_z
  output logic [183:0]                   m_axis_tdata,
  // w_was_zero
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);

  localparam int AW = vpr_pkg::ACC_W;
  localparam int NS = vpr_pkg::DIV_STAGES;
  localparam logic [14:0] MAXW = 15'(MAX_WIDTH);
  localparam logic [14:0] MAXH = 15'(MAX_HEIGHT);
  localparam logic signed [38:0] Q24_39 = 39'sd16777216;
  localparam logic signed [27:0] Q24_28 = 28'sd16777216;

  logic [63:0] row_q [4];
  logic [25:0] xs_q, ys_q;
  logic        en;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= vpr_pkg::ROW0_RST;
      row_q[1] <= vpr_pkg::ROW1_RST;
      row_q[2] <= vpr_pkg::ROW2_RST;
      row_q[3] <= vpr_pkg::ROW3_RST;
      xs_q     <= vpr_pkg::SCALE_RST;
      ys_q     <= vpr_pkg::SCALE_RST;
    end else if (cfg_valid_i) begin
      case (vpr_pkg::cfg_idx_e'(cfg_index_i))
        vpr_pkg::CFG_ROW0:   row_q[0] <= cfg_data_i;
        vpr_pkg::CFG_ROW1:   row_q[1] <= cfg_data_i;
        vpr_pkg::CFG_ROW2:   row_q[2] <= cfg_data_i;
        vpr_pkg::CFG_ROW3:   row_q[3] <= cfg_data_i;
        vpr_pkg::CFG_XSCALE: xs_q     <= cfg_data_i[25:0];
        vpr_pkg::CFG_YSCALE: ys_q     <= cfg_data_i[25:0];
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: decode, NDC
  logic [11:0] in_px, in_py;
  logic [31:0] in_code, in_pay, dbits;
  logic        keep;
  logic [38:0] xprod, yprod;
  logic [7:0]  fexp, fsh;
  logic [23:0] fmag;
  logic signed [23:0] q22;
  logic signed [38:0] cx_d, cy_d;
  logic signed [27:0] cz_d;

  assign in_px   = s_axis_tdata[11:0];
  assign in_py   = s_axis_tdata[23:12];
  assign in_code = s_axis_tdata[55:24];
  assign in_pay  = s_axis_tdata[87:56];
  assign keep    = (in_pay != vpr_pkg::EMPTY_PAYLOAD) && (15'(in_px) < MAXW)
                   && (15'(in_py) < MAXH);
  assign dbits   = in_code[31] ? (in_code ^ vpr_pkg::Q16_MIN) : ~in_code;

  assign xprod = 39'({in_px, 1'b1}) * 39'(xs_q);
  assign yprod = 39'({in_py, 1'b1}) * 39'(ys_q);
  assign cx_d  = $signed({1'b0, xprod[38:1]}) - Q24_39;
  assign cy_d  = $signed({1'b0, yprod[38:1]}) - Q24_39;

  assign fexp = dbits[30:23];
  assign fsh  = 8'd128 - fexp;

  always_comb begin
    fmag = (fsh > 8'd24) ? 24'h0 : ({1'b1, dbits[22:0]} >> fsh);
    if (fexp == 8'hFF) begin
      if (dbits[22:0] != 23'h0) q22 = '0;
      else q22 = dbits[31] ? 24'sh800000 : 24'sh7FFFFF;
    end else if (fexp == 8'h00) begin
      q22 = '0;
    end else if (fexp >= 8'd128) begin
      q22 = dbits[31] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      q22 = dbits[31] ? -$signed(fmag) : $signed(fmag);
    end
  end

  assign cz_d = $signed({q22[23], q22, 3'b000}) - Q24_28;

  vpr_pkg::pix_t      s1_pix_q, s2_pix_q, s3_pix_q, s4_pix_q;
  logic signed [38:0] s1_cx_q, s1_cy_q;
  logic signed [27:0] s1_cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q <= '0;
    end else if (en) begin
      s1_pix_q.valid <= s_axis_tvalid && keep;
      s1_pix_q.px    <= in_px;
      s1_pix_q.py    <= in_py;
      s1_pix_q.cid   <= in_pay[31:16];
      s1_pix_q.tid   <= in_pay[15:8];
      s1_pix_q.mid   <= in_pay[7:0];
      s1_pix_q.dbits <= dbits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cx_q        <= cx_d;
      s1_cy_q        <= cy_d;
      s1_cz_q        <= cz_d;
    end
  end

  // stage 2: products
  logic signed [54:0] s2_px_q [4];
  logic signed [54:0] s2_py_q [4];
  logic signed [43:0] s2_pz_q [4];
  logic signed [39:0] s2_pw_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s2_px_q[r] <= vpr_pkg::coef(row_q[r], 2'd0) * s1_cx_q;
        s2_py_q[r] <= vpr_pkg::coef(row_q[r], 2'd1) * s1_cy_q;
        s2_pz_q[r] <= vpr_pkg::coef(row_q[r], 2'd2) * s1_cz_q;
        s2_pw_q[r] <= $signed({vpr_pkg::coef(row_q[r], 2'd3), 24'h000000});
      end
    end
  end

  // stage 3: row sums
  logic signed [AW-1:0] s3_acc_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s3_acc_q[r] <= AW'(s2_px_q[r]) + AW'(s2_py_q[r]) + AW'(s2_pz_q[r])
                       + AW'(s2_pw_q[r]);
      end
    end
  end

  // stage 4: magnitudes, signs, undivided result
  logic [AW-1:0] s4_num_q [3];
  logic [AW-1:0] s4_den_q;
  vpr_pkg::res_t s4_res_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s4_num_q[r]       <= s3_acc_q[r][AW-1] ? AW'(-s3_acc_q[r]) : AW'(s3_acc_q[r]);
        s4_res_q.neg[r]   <= s3_acc_q[r][AW-1] ^ s3_acc_q[3][AW-1];
        s4_res_q.undiv[r] <= vpr_pkg::sat_undiv(s3_acc_q[r]);
      end
      s4_den_q       <= s3_acc_q[3][AW-1] ? AW'(-s3_acc_q[3]) : AW'(s3_acc_q[3]);
      s4_res_q.wzero <= (s3_acc_q[3] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_pix_q <= '0;
      s3_pix_q <= '0;
      s4_pix_q <= '0;
    end else if (en) begin
      s2_pix_q <= s1_pix_q;
      s3_pix_q <= s2_pix_q;
      s4_pix_q <= s3_pix_q;
    end
  end

  // divide by w
  logic [NS-1:0] quo [3];
  logic          ovf [3];

  for (genvar r = 0; r < 3; r++) begin : g_div
    vpr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s4_num_q[r]),
      .den_i (s4_den_q),
      .quo_o (quo[r]),
      .ovf_o (ovf[r])
    );
  end

  // side data alongside the divider
  vpr_pkg::pix_t dl_pix_q [NS];
  vpr_pkg::res_t dl_res_q [NS];
  logic [NS-1:0] dl_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_valid_q <= '0;
    end else if (en) begin
      dl_valid_q <= {dl_valid_q[NS-2:0], s4_pix_q.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_pix_q[0] <= s4_pix_q;
      dl_res_q[0] <= s4_res_q;
      for (int s = 1; s < NS; s++) begin
        dl_pix_q[s] <= dl_pix_q[s-1];
        dl_res_q[s] <= dl_res_q[s-1];
      end
    end
  end

  // output stage
  vpr_pkg::pix_t    o_pix;
  vpr_pkg::res_t    o_res;
  logic [2:0][31:0] world_d;
  logic [2:0][31:0] world_q;
  vpr_pkg::pix_t    out_pix_q;
  logic             out_wz_q, out_valid_q;

  assign o_pix = dl_pix_q[NS-1];
  assign o_res = dl_res_q[NS-1];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (o_res.wzero) world_d[r] = o_res.undiv[r];
      else if (ovf[r]) world_d[r] = o_res.neg[r] ? vpr_pkg::Q16_MIN : vpr_pkg::Q16_MAX;
      else world_d[r] = o_res.neg[r] ? 32'(-{1'b0, quo[r]}) : 32'({1'b0, quo[r]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dl_valid_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q <= o_pix;
      out_wz_q  <= o_res.wzero;
      world_q   <= world_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {world_q[2], world_q[1], world_q[0], out_pix_q.dbits,
                          out_pix_q.mid, out_pix_q.tid, out_pix_q.cid,
                          out_pix_q.py, out_pix_q.px};
  assign m_axis_tuser  = out_wz_q;

`ifndef NO_ASSERTIONS
  a_empty_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[87:56] == vpr_pkg::EMPTY_PAYLOAD)
    |=> !s1_pix_q.valid)
    else $error("empty pixel entered the pipeline");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_xscale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == vpr_pkg::CFG_XSCALE)
    |=> xs_q == $past(cfg_data_i[25:0]))
    else $error("x scale write lost");

  a_wzero_undiv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && dl_valid_q[NS-1] && o_res.wzero) |=> world_q[0] == $past(o_res.undiv[0]))
    else $error("zero w result not taken from row sum");
`endif

endmodule
